@@ src/ndef_pkg.sv @@
// ----------------------------------------------------------------------------
// NDEF parser package
// Byte kind and status codes, header flag masks and field widths.
// ----------------------------------------------------------------------------
package ndef_pkg;

  localparam int unsigned LEN_W = 16;

  typedef enum logic [2:0] {
    KIND_FLAGS   = 3'd0,
    KIND_TLEN    = 3'd1,
    KIND_PLEN    = 3'd2,
    KIND_ILEN    = 3'd3,
    KIND_TYPE    = 3'd4,
    KIND_ID      = 3'd5,
    KIND_PAYLOAD = 3'd6,
    KIND_IGNORED = 3'd7
  } byte_kind_t;

  typedef enum logic [1:0] {
    ST_BUSY      = 2'd0,
    ST_COMPLETE  = 2'd1,
    ST_MALFORMED = 2'd2
  } status_t;

  localparam logic [7:0] FLAG_ME  = 8'h40;
  localparam logic [7:0] FLAG_SR  = 8'h10;
  localparam logic [7:0] FLAG_IL  = 8'h08;
  localparam logic [7:0] TNF_MASK = 8'h07;

endpackage

@@ src/ndef_message_parser.sv @@
// ----------------------------------------------------------------------------
// NDEF message parser
// Tags each byte of an NDEF message with its role and reports record headers.
// ----------------------------------------------------------------------------
// One result per input byte. A byte is taken in every cycle in which the
// output register is empty or being drained, and its result appears in the
// next cycle; the parse state advances once per byte, so the sustained
// rate is one byte per clock, limited only by out_tready. message_length must
// be written while the stream is idle; a byte with in_tuser set restarts the
// parse and counts as byte 0 of the message.
module ndef_message_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,    // message_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,       // [7:0] data_byte
  input  logic [0:0]  in_tuser,       // [0] message_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,      // [1:0] status, [2] record_valid,
                                      // [5:3] record_tnf, [13:6] type_length,
                                      // [21:14] id_length,
                                      // [37:22] payload_length, [39:38] zero
  output logic [2:0]  out_tuser,      // [2:0] byte_kind
  output logic        out_tlast       // record_last_byte
);

  typedef enum logic [2:0] {
    PH_FLAGS = 3'd0,
    PH_TLEN  = 3'd1,
    PH_PLEN  = 3'd2,
    PH_ILEN  = 3'd3,
    PH_TYPE  = 3'd4,
    PH_ID    = 3'd5,
    PH_PAY   = 3'd6,
    PH_END   = 3'd7
  } phase_t;

  localparam int unsigned W = ndef_pkg::LEN_W;

  logic [W-1:0]  msg_len_r;
  phase_t        phase_r, phase_nxt, cur_phase;
  logic [W-1:0]  consumed_r, consumed_nxt, cur_consumed;
  logic [7:0]    flags_r, flags_nxt, cur_flags;
  logic [7:0]    tlen_r, tlen_nxt, cur_tlen;
  logic [7:0]    ilen_r, ilen_nxt, cur_ilen;
  logic [31:0]   plen_r, plen_nxt, cur_plen;
  logic [W-1:0]  cnt_r, cnt_nxt, cur_cnt;
  logic [1:0]    lidx_r, lidx_nxt, cur_lidx;
  ndef_pkg::status_t outcome_r, outcome_nxt, cur_outcome;

  logic          out_valid_r;
  logic [39:0]   out_data_r;
  logic [2:0]    out_kind_r;
  logic          out_last_r;

  ndef_pkg::byte_kind_t kind;
  logic          ended, do_validate, do_next, fits, valid, last, body, hdr_end;
  logic [1:0]    stage;
  logic [W-1:0]  rem, rem_m1, cnt_dec;
  logic [W+1:0]  hdr_sum;
  logic [15:0]   pay_out;
  logic          accept;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    if (in_tuser[0]) begin
      cur_phase    = PH_FLAGS;
      cur_consumed = '0;
      cur_flags    = '0;
      cur_tlen     = '0;
      cur_ilen     = '0;
      cur_plen     = '0;
      cur_cnt      = '0;
      cur_lidx     = '0;
      cur_outcome  = ndef_pkg::ST_BUSY;
    end else begin
      cur_phase    = phase_r;
      cur_consumed = consumed_r;
      cur_flags    = flags_r;
      cur_tlen     = tlen_r;
      cur_ilen     = ilen_r;
      cur_plen     = plen_r;
      cur_cnt      = cnt_r;
      cur_lidx     = lidx_r;
      cur_outcome  = outcome_r;
    end
  end

  always_comb begin
    phase_nxt    = cur_phase;
    consumed_nxt = cur_consumed;
    flags_nxt    = cur_flags;
    tlen_nxt     = cur_tlen;
    ilen_nxt     = cur_ilen;
    plen_nxt     = cur_plen;
    cnt_nxt      = cur_cnt;
    lidx_nxt     = cur_lidx;
    outcome_nxt  = cur_outcome;
    kind         = ndef_pkg::KIND_IGNORED;
    ended        = 1'b0;
    do_validate  = 1'b0;
    do_next      = 1'b0;
    stage        = 2'd0;
    hdr_end      = 1'b0;
    body         = 1'b0;
    valid        = 1'b0;
    last         = 1'b0;
    fits         = 1'b0;
    hdr_sum      = '0;
    rem          = msg_len_r - cur_consumed;
    rem_m1       = rem - W'(1);
    cnt_dec      = (cur_cnt != '0) ? cur_cnt - W'(1) : cur_cnt;

    if (cur_phase == PH_END || cur_consumed >= msg_len_r) begin
      ended = 1'b1;
      if (cur_phase != PH_END) begin
        outcome_nxt = (cur_phase == PH_FLAGS) ? ndef_pkg::ST_COMPLETE
                                              : ndef_pkg::ST_MALFORMED;
        phase_nxt   = PH_END;
      end
    end else begin
      consumed_nxt = cur_consumed + W'(1);
      unique case (cur_phase)
        PH_FLAGS: begin
          kind      = ndef_pkg::KIND_FLAGS;
          flags_nxt = in_tdata;
          tlen_nxt  = '0;
          ilen_nxt  = '0;
          plen_nxt  = '0;
          cnt_nxt   = '0;
          lidx_nxt  = '0;
          if (rem < W'(3)) begin
            outcome_nxt = ndef_pkg::ST_MALFORMED;
            phase_nxt   = PH_END;
          end else begin
            phase_nxt = PH_TLEN;
          end
        end
        PH_TLEN: begin
          kind      = ndef_pkg::KIND_TLEN;
          tlen_nxt  = in_tdata;
          plen_nxt  = '0;
          lidx_nxt  = '0;
          phase_nxt = PH_PLEN;
        end
        PH_PLEN: begin
          kind = ndef_pkg::KIND_PLEN;
          if ((cur_flags & ndef_pkg::FLAG_SR) != '0) begin
            plen_nxt = {24'd0, in_tdata};
            hdr_end  = 1'b1;
          end else if (cur_lidx == 2'd0 && rem < W'(4)) begin
            outcome_nxt = ndef_pkg::ST_MALFORMED;
            phase_nxt   = PH_END;
          end else begin
            plen_nxt = {cur_plen[23:0], in_tdata};
            if (cur_lidx == 2'd3) begin
              lidx_nxt = '0;
              hdr_end  = 1'b1;
            end else begin
              lidx_nxt = cur_lidx + 2'd1;
            end
          end
          if (hdr_end) begin
            if ((cur_flags & ndef_pkg::FLAG_IL) != '0) begin
              if (rem < W'(2)) begin
                outcome_nxt = ndef_pkg::ST_MALFORMED;
                phase_nxt   = PH_END;
              end else begin
                phase_nxt = PH_ILEN;
              end
            end else begin
              do_validate = 1'b1;
            end
          end
        end
        PH_ILEN: begin
          kind        = ndef_pkg::KIND_ILEN;
          ilen_nxt    = in_tdata;
          do_validate = 1'b1;
        end
        PH_TYPE, PH_ID, PH_PAY: begin
          unique case (cur_phase)
            PH_TYPE: begin
              kind  = ndef_pkg::KIND_TYPE;
              stage = 2'd1;
            end
            PH_ID: begin
              kind  = ndef_pkg::KIND_ID;
              stage = 2'd2;
            end
            default: begin
              kind  = ndef_pkg::KIND_PAYLOAD;
              stage = 2'd3;
            end
          endcase
          body    = 1'b1;
          cnt_nxt = cnt_dec;
          do_next = (cnt_dec == '0);
        end
        default: begin
          kind = ndef_pkg::KIND_IGNORED;
        end
      endcase

      // header check: type + id + payload must fit in what follows this byte
      hdr_sum = (W+2)'(tlen_nxt) + (W+2)'(ilen_nxt) + (W+2)'(plen_nxt[15:0]);
      fits    = (plen_nxt[31:16] == '0) && (hdr_sum <= (W+2)'(rem_m1));
      if (do_validate) begin
        if (fits) begin
          valid   = 1'b1;
          do_next = 1'b1;
          stage   = 2'd0;
        end else begin
          outcome_nxt = ndef_pkg::ST_MALFORMED;
          phase_nxt   = PH_END;
        end
      end

      if (do_next) begin
        if (stage == 2'd0 && tlen_nxt != '0) begin
          phase_nxt = PH_TYPE;
          cnt_nxt   = W'(tlen_nxt);
        end else if (stage <= 2'd1 && ilen_nxt != '0) begin
          phase_nxt = PH_ID;
          cnt_nxt   = W'(ilen_nxt);
        end else if (stage <= 2'd2 && plen_nxt != '0) begin
          phase_nxt = PH_PAY;
          cnt_nxt   = plen_nxt[W-1:0];
        end else begin
          last = 1'b1;
          if ((flags_nxt & ndef_pkg::FLAG_ME) != '0 || rem <= W'(1)) begin
            outcome_nxt = ndef_pkg::ST_COMPLETE;
            phase_nxt   = PH_END;
          end else begin
            phase_nxt = PH_FLAGS;
          end
        end
      end
    end

    pay_out = (valid || body) ? plen_nxt[15:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msg_len_r   <= '0;
      phase_r     <= PH_FLAGS;
      consumed_r  <= '0;
      flags_r     <= '0;
      tlen_r      <= '0;
      ilen_r      <= '0;
      plen_r      <= '0;
      cnt_r       <= '0;
      lidx_r      <= '0;
      outcome_r   <= ndef_pkg::ST_BUSY;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
      out_kind_r  <= '0;
      out_last_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        msg_len_r <= cfg_wr_data;
      end
      if (accept) begin
        phase_r     <= phase_nxt;
        consumed_r  <= consumed_nxt;
        flags_r     <= flags_nxt;
        tlen_r      <= tlen_nxt;
        ilen_r      <= ilen_nxt;
        plen_r      <= plen_nxt;
        cnt_r       <= cnt_nxt;
        lidx_r      <= lidx_nxt;
        outcome_r   <= outcome_nxt;
        out_valid_r <= 1'b1;
        out_kind_r  <= kind;
        out_last_r  <= last && !ended;
        if (ended) begin
          out_data_r <= {38'd0, outcome_nxt};
        end else begin
          out_data_r <= {2'b00, pay_out, ilen_nxt, tlen_nxt,
                         flags_nxt[2:0] & ndef_pkg::TNF_MASK[2:0], valid, outcome_nxt};
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

@@ dv/tb_ndef_message_parser.sv @@
// ----------------------------------------------------------------------------
// NDEF message parser testbench
// Streams NDEF messages through the parser, predicts the tag of each byte and
// the record fields with a local model, and checks every result in order.
// A short directed table covers header shapes, truncation and oversized
// fields; random messages follow under changing idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_ndef_message_parser;

  localparam int MIN_PARSED  = 1500;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    ndef_pkg::byte_kind_t kind;
    ndef_pkg::status_t    status;
    logic        valid;
    logic [2:0]  tnf;
    logic [7:0]  tlen;
    logic [7:0]  ilen;
    logic [15:0] plen;
    logic        rec_last;
  } parse_result_t;

  typedef struct packed {
    logic          wr;
    logic [15:0]   len;
    logic          start;
    logic [7:0]    data;
    logic          typed;
    parse_result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  parse_result_t expected_results [$];
  int errors = 0;
  int cycles = 0;
  int parsed_bytes = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  // parser state
  logic [15:0] msg_len;
  ndef_pkg::byte_kind_t phase;
  logic [15:0] consumed;
  logic [7:0]  hdr;
  logic [7:0]  tlen_q;
  logic [7:0]  ilen_q;
  logic [31:0] plen_q;
  logic [31:0] remaining;
  logic [1:0]  len_idx;
  ndef_pkg::status_t outcome;

  ndef_message_parser uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[ndef_message_parser] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void restart_parse();
    phase     = ndef_pkg::KIND_FLAGS;
    consumed  = '0;
    hdr       = '0;
    tlen_q    = '0;
    ilen_q    = '0;
    plen_q    = '0;
    remaining = '0;
    len_idx   = '0;
    outcome   = ndef_pkg::ST_BUSY;
  endfunction

  function automatic void set_malformed();
    outcome = ndef_pkg::ST_MALFORMED;
    phase   = ndef_pkg::KIND_IGNORED;
  endfunction

  // stage: 0 after header, 1 after type, 2 after id, 3 after payload; returns 1 when the record ends
  function automatic logic advance_field(input int stage, input logic [31:0] rem);
    if (stage < 1 && tlen_q != 0) begin
      phase = ndef_pkg::KIND_TYPE;
      remaining = 32'(tlen_q);
      return 1'b0;
    end
    if (stage < 2 && ilen_q != 0) begin
      phase = ndef_pkg::KIND_ID;
      remaining = 32'(ilen_q);
      return 1'b0;
    end
    if (stage < 3 && plen_q != 0) begin
      phase = ndef_pkg::KIND_PAYLOAD;
      remaining = plen_q;
      return 1'b0;
    end
    if ((hdr & ndef_pkg::FLAG_ME) != 0 || rem <= 32'd1) begin
      outcome = ndef_pkg::ST_COMPLETE;
      phase = ndef_pkg::KIND_IGNORED;
    end else begin
      phase = ndef_pkg::KIND_FLAGS;
    end
    return 1'b1;
  endfunction

  // returns {valid, record ends here}
  function automatic logic [1:0] check_record(input logic [31:0] rem);
    logic [31:0] left;
    left = rem - 32'd1;
    if (32'(tlen_q) > left) begin
      set_malformed();
      return 2'b00;
    end
    left -= 32'(tlen_q);
    if (32'(ilen_q) > left) begin
      set_malformed();
      return 2'b00;
    end
    left -= 32'(ilen_q);
    if (plen_q > left) begin
      set_malformed();
      return 2'b00;
    end
    return {1'b1, advance_field(0, rem)};
  endfunction

  function automatic parse_result_t parse_byte(input logic [7:0] b, input logic start);
    parse_result_t r;
    logic [31:0] off;
    logic [31:0] rem;
    logic valid;
    logic rec_last;
    logic body;
    logic hdr_end;
    if (start) restart_parse();
    r = '0;
    valid = 1'b0;
    rec_last = 1'b0;
    body = 1'b0;
    hdr_end = 1'b0;
    off = 32'(consumed);
    if (phase == ndef_pkg::KIND_IGNORED || off >= 32'(msg_len)) begin
      if (phase != ndef_pkg::KIND_IGNORED) begin
        outcome = (phase == ndef_pkg::KIND_FLAGS) ? ndef_pkg::ST_COMPLETE
                                                  : ndef_pkg::ST_MALFORMED;
        phase = ndef_pkg::KIND_IGNORED;
      end
      r.kind = ndef_pkg::KIND_IGNORED;
      r.status = outcome;
      return r;
    end
    if (consumed != 16'hFFFF) consumed++;
    rem = 32'(msg_len) - off;
    r.kind = phase;
    case (phase)
      ndef_pkg::KIND_FLAGS: begin
        hdr = b;
        tlen_q = '0;
        ilen_q = '0;
        plen_q = '0;
        remaining = '0;
        len_idx = '0;
        if (rem < 32'd3) set_malformed();
        else phase = ndef_pkg::KIND_TLEN;
      end
      ndef_pkg::KIND_TLEN: begin
        tlen_q = b;
        plen_q = '0;
        len_idx = '0;
        phase = ndef_pkg::KIND_PLEN;
      end
      ndef_pkg::KIND_PLEN: begin
        if ((hdr & ndef_pkg::FLAG_SR) != 0) begin
          plen_q = 32'(b);
          hdr_end = 1'b1;
        end else if (len_idx == 2'd0 && rem < 32'd4) begin
          set_malformed();
        end else begin
          plen_q = {plen_q[23:0], b};
          if (len_idx == 2'd3) begin
            len_idx = '0;
            hdr_end = 1'b1;
          end else begin
            len_idx++;
          end
        end
        if (hdr_end) begin
          if ((hdr & ndef_pkg::FLAG_IL) != 0) begin
            if (rem < 32'd2) set_malformed();
            else phase = ndef_pkg::KIND_ILEN;
          end else begin
            {valid, rec_last} = check_record(rem);
          end
        end
      end
      ndef_pkg::KIND_ILEN: begin
        ilen_q = b;
        {valid, rec_last} = check_record(rem);
      end
      default: begin
        body = 1'b1;
        if (remaining != 0) remaining--;
        if (remaining == 0)
          rec_last = advance_field(int'(phase) - int'(ndef_pkg::KIND_TYPE) + 1, rem);
      end
    endcase
    r.status   = outcome;
    r.valid    = valid;
    r.tnf      = hdr[2:0];
    r.tlen     = tlen_q;
    r.ilen     = ilen_q;
    r.plen     = (valid || body) ? plen_q[15:0] : 16'd0;
    r.rec_last = rec_last;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    parse_result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got tdata %h tuser %h",
                 $time, out_tdata, out_tuser);
        errors++;
      end else begin
        want = expected_results.pop_front();
        compare_field("byte_kind", 16'(want.kind), 16'(out_tuser));
        compare_field("status", 16'(want.status), 16'(out_tdata[1:0]));
        compare_field("record_valid", 16'(want.valid), 16'(out_tdata[2]));
        compare_field("record_tnf", 16'(want.tnf), 16'(out_tdata[5:3]));
        compare_field("type_length", 16'(want.tlen), 16'(out_tdata[13:6]));
        compare_field("id_length", 16'(want.ilen), 16'(out_tdata[21:14]));
        compare_field("payload_length", want.plen, out_tdata[37:22]);
        compare_field("record_last_byte", 16'(want.rec_last), 16'(out_tlast));
      end
    end
  end

  task automatic push_byte(input logic start, input logic [7:0] data,
                           input logic typed, input parse_result_t want);
    parse_result_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= start;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    predicted = parse_byte(data, start);
    if (typed) predicted = want;
    parsed_bytes++;
    expected_results.push_back(predicted);
  endtask

  task automatic write_length(input logic [15:0] len);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    msg_len = len;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random_message();
    logic [7:0]  msg [$];
    logic [7:0]  fl;
    logic [31:0] pl_field;
    int n_rec;
    int tl;
    int il;
    int pl;
    int extra;
    int len;
    n_rec = $urandom_range(1, 4);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom));
    end else begin
      for (int r = 0; r < n_rec; r++) begin
        fl = 8'($urandom);
        fl[6] = (r == n_rec - 1) ? ($urandom_range(7) != 0) : ($urandom_range(7) == 0);
        fl[4] = ($urandom_range(3) != 0);
        tl = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(3);
        il = !fl[3] ? 0 : ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(3);
        pl = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        // now and then a payload length far beyond the message
        pl_field = ($urandom_range(24) == 0) ? $urandom : 32'(pl);
        msg.push_back(fl);
        msg.push_back(8'(tl));
        if (fl[4]) msg.push_back(pl_field[7:0]);
        else for (int k = 3; k >= 0; k--) msg.push_back(pl_field[8*k +: 8]);
        if (fl[3]) msg.push_back(8'(il));
        repeat (tl + il + pl) msg.push_back(8'($urandom));
      end
    end
    case ($urandom_range(19))
      0:       len = 0;
      1:       len = 65535;
      2, 3:    len = $urandom_range(msg.size());
      4, 5:    len = msg.size() + $urandom_range(1, 6);
      default: len = msg.size();
    endcase
    write_length(16'(len));
    extra = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (extra) msg.push_back(8'($urandom));
    foreach (msg[i])
      push_byte(i == 0 || $urandom_range(63) == 0, msg[i], 1'b0, '0);
  endtask

  stim_row_t plan [26] = '{
    // length still at reset value: first byte already complete
    '{1'b0, 16'd0, 1'b1, 8'hFF, 1'b1,
      '{ndef_pkg::KIND_IGNORED, ndef_pkg::ST_COMPLETE, 1'b0, 3'd0, 8'd0, 8'd0,
        16'd0, 1'b0}},
    // short record, ME set, maximum length
    '{1'b1, 16'hFFFF, 1'b1, 8'hD1, 1'b1,
      '{ndef_pkg::KIND_FLAGS, ndef_pkg::ST_BUSY, 1'b0, 3'd1, 8'd0, 8'd0,
        16'd0, 1'b0}},
    '{1'b0, 16'd0, 1'b0, 8'h01, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'h54, 1'b0, '0},
    // long payload length with id, then a truncated header
    '{1'b1, 16'd12, 1'b1, 8'h8F, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'h01, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'h01, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'h01, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'hFF, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'hAA, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'h11, 1'b1,
      '{ndef_pkg::KIND_FLAGS, ndef_pkg::ST_MALFORMED, 1'b0, 3'd1, 8'd0, 8'd0,
        16'd0, 1'b0}},
    // oversized type field
    '{1'b1, 16'd8, 1'b1, 8'h51, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'hFF, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'h02, 1'b1,
      '{ndef_pkg::KIND_PLEN, ndef_pkg::ST_MALFORMED, 1'b0, 3'd1, 8'hFF, 8'd0,
        16'd0, 1'b0}},
    // empty body ends exactly at the message length
    '{1'b1, 16'd3, 1'b1, 8'h10, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'h00, 1'b1,
      '{ndef_pkg::KIND_PLEN, ndef_pkg::ST_COMPLETE, 1'b1, 3'd0, 8'd0, 8'd0,
        16'd0, 1'b1}},
    // length shrinks under a payload in flight
    '{1'b1, 16'd100, 1'b1, 8'h16, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'h00, 1'b0, '0},
    '{1'b0, 16'd0, 1'b0, 8'h05, 1'b0, '0},
    '{1'b1, 16'd3, 1'b0, 8'h33, 1'b1,
      '{ndef_pkg::KIND_IGNORED, ndef_pkg::ST_MALFORMED, 1'b0, 3'd0, 8'd0, 8'd0,
        16'd0, 1'b0}}
  };

  initial begin : stimulus
    int msg_idx;
    msg_idx = 0;
    msg_len = '0;
    restart_parse();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    foreach (plan[i]) begin
      if (plan[i].wr) write_length(plan[i].len);
      push_byte(plan[i].start, plan[i].data, plan[i].typed, plan[i].want);
    end
    while (parsed_bytes < MIN_PARSED) begin
      case ((msg_idx / 6) % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 50;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 50;
        end
        default: begin
          idle_pct = 35;
          stall_pct = 35;
        end
      endcase
      send_random_message();
      msg_idx++;
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[ndef_message_parser] OK");
    end else begin
      $display("[ndef_message_parser] ERROR");
    end
    $finish;
  end

endmodule
